### rtl/core/gpf_pkg.sv
// Shared types, constants and saturation helpers for the gravity pair-force step core.
// No dependencies; imported by gpf_dp, gpf_ctrl and the top core module.
`default_nettype none
package gpf_pkg;

    localparam int MAX_PARTICLES_DEF = 64;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int DT_W              = 17;
    localparam logic [DT_W-1:0] DT_RESET = 17'd656;
    localparam int IDX_OUT_W         = 6;
    localparam int S_TDATA_W         = 160;
    localparam int M_TDATA_W         = 136;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CLR, OP_CAPI, OP_CAPJ, OP_ABS, OP_MAA, OP_MBB, OP_MMM,
        OP_START1, OP_PCAP, OP_PLO, OP_PHI, OP_START2, OP_MCAP, OP_FWRI, OP_FWRJ,
        OP_UCAP, OP_UMF, OP_UV, OP_UMV, OP_UX, OP_UWR
    } dp_op_t;

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE, ST_CLR, ST_RDI, ST_RDJ, ST_CAPJ, ST_ABS, ST_MAA, ST_MBB, ST_MMM,
        ST_CHK, ST_W1, ST_PLO, ST_PHI, ST_D2S, ST_W2, ST_FRDI, ST_FWRI, ST_FWRJ,
        ST_URD, ST_UCAP, ST_UMF, ST_UV, ST_UMV, ST_UX, ST_UWR, ST_OUT
    } st_t;

    typedef struct packed {
        dp_op_t op;
        logic   comp;   // 0: x component, 1: y component
        logic   last;   // final particle of the step
    } cmd_t;

    typedef struct packed {
        logic s_zero;      // squared distance is zero
        logic units_idle;  // divider and square root both finished
    } status_t;

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32_fn(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic ovf32_fn(input logic signed [63:0] v);
        return (v > 64'sd2147483647) || (v < -64'sd2147483648);
    endfunction

endpackage
`default_nettype wire

### rtl/core/gpf_div.sv
// Iterative restoring divider, 128/64 bits, one quotient bit per cycle, saturating.
// Depends on nothing; used by gpf_dp.
`default_nettype none
module gpf_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] num_hi,
    input  wire logic [63:0] num_lo,
    input  wire logic [63:0] den,
    output logic             busy,
    output logic [63:0]      quot
);
    logic [63:0] rem_reg, lo_reg, q_reg, den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [63:0] rem_sh;
    logic        carry, take;

    // one restoring step
    always_comb begin
        carry  = rem_reg[63];
        rem_sh = {rem_reg[62:0], lo_reg[63]};
        take   = carry || (rem_sh >= den_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= (num_hi < den);
        end else if (busy_reg && (cnt_reg == 6'd63)) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num_hi;
            lo_reg  <= num_lo;
            den_reg <= den;
            cnt_reg <= '0;
            q_reg   <= (num_hi >= den) ? '1 : '0;
        end else if (busy_reg) begin
            rem_reg <= take ? (rem_sh - den_reg) : rem_sh;
            lo_reg  <= {lo_reg[62:0], 1'b0};
            q_reg   <= {q_reg[62:0], take};
            cnt_reg <= cnt_reg + 6'd1;
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;
endmodule
`default_nettype wire

### rtl/core/gpf_sqrt.sv
// Iterative integer square root of a 64-bit value, one result bit per cycle.
// Depends on nothing; used by gpf_dp.
`default_nettype none
module gpf_sqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] val,
    output logic             busy,
    output logic [31:0]      root
);
    logic [63:0] v_reg, r_reg, bit_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [63:0] trial;

    assign trial = r_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && (cnt_reg == 5'd31)) begin
            busy_reg <= 1'b0;
        end
    end

    // digit-by-digit root, two radicand bits a step
    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= val;
            r_reg   <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            if (v_reg >= trial) begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
            cnt_reg <= cnt_reg + 5'd1;
        end
    end

    assign busy = busy_reg;
    assign root = r_reg[31:0];
endmodule
`default_nettype wire

### rtl/core/gpf_dp.sv
// Datapath: particle stores, shared multiplier, divider and square root units, update math.
// Depends on gpf_pkg, gpf_div and gpf_sqrt.
`default_nettype none
module gpf_dp #(
    parameter int MAX_PARTICLES = gpf_pkg::MAX_PARTICLES_DEF,
    parameter int FRAC_BITS     = gpf_pkg::FRAC_BITS_DEF,
    localparam int IDX_W        = $clog2(MAX_PARTICLES)
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire gpf_pkg::cmd_t              cmd,
    input  wire logic [IDX_W-1:0]           rd_addr,
    input  wire logic [IDX_W-1:0]           wr_addr,
    input  wire logic [gpf_pkg::DT_W-1:0]   dt,
    input  wire logic signed [31:0]         in_pos_x,
    input  wire logic signed [31:0]         in_pos_y,
    input  wire logic signed [31:0]         in_vel_x,
    input  wire logic signed [31:0]         in_vel_y,
    input  wire logic [31:0]                in_mass,
    output gpf_pkg::status_t                status,
    output logic [gpf_pkg::IDX_OUT_W-1:0]   out_idx,
    output logic signed [31:0]              out_pos_x,
    output logic signed [31:0]              out_pos_y,
    output logic signed [31:0]              out_vel_x,
    output logic signed [31:0]              out_vel_y,
    output logic                            out_sat,
    output logic                            out_last
);
    import gpf_pkg::*;

    // stores
    logic [63:0] pos_mem [MAX_PARTICLES];
    logic [63:0] vel_mem [MAX_PARTICLES];
    logic [31:0] mass_mem [MAX_PARTICLES];
    logic [64:0] frc_mem [MAX_PARTICLES];   // {flag, fy, fx}
    logic [63:0] pos_rd, vel_rd;
    logic [31:0] mass_rd;
    logic [64:0] frc_rd;

    // pair working registers
    logic signed [31:0] pix_reg, piy_reg;
    logic [31:0]        mi_reg, mj_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic [31:0]        a_reg, b_reg;
    logic               k_reg, dxp_reg, dyp_reg;
    logic signed [65:0] mul_reg;
    logic [63:0]        s_reg, p_reg, plo_reg;
    logic [31:0]        f_reg;
    logic               psat_reg;

    // update working registers
    logic signed [31:0] ux_reg, uy_reg, uvx_reg, uvy_reg, ufx_reg, ufy_reg;
    logic               uflag_reg;

    // output registers
    logic [IDX_OUT_W-1:0] oidx_reg;
    logic signed [31:0]   opx_reg, opy_reg, ovx_reg, ovy_reg;
    logic                 osat_reg, olast_reg;

    // units
    logic         div_start, sq_start, div_busy, sq_busy;
    logic [63:0]  div_hi, div_lo, div_den, div_q;
    logic [31:0]  sq_root;
    logic [127:0] num1, num2;

    // combinational helpers
    logic signed [32:0] ma, mb;
    logic signed [65:0] mul_next, dv;
    logic [32:0]        ax, ay;
    logic               kk;
    logic signed [31:0] fo_c, fnew;
    logic signed [33:0] fmag, fsum;
    logic               fneg, fovf;
    logic [64:0]        fword;
    logic signed [31:0] v_c, x_c;
    logic signed [63:0] vsum, xsum;
    logic [31:0]        idx32;

    gpf_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num_hi(div_hi), .num_lo(div_lo), .den(div_den),
        .busy(div_busy), .quot(div_q)
    );

    gpf_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start), .val(s_reg),
        .busy(sq_busy), .root(sq_root)
    );

    // store writes
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            pos_mem[wr_addr]  <= {in_pos_y, in_pos_x};
            vel_mem[wr_addr]  <= {in_vel_y, in_vel_x};
            mass_mem[wr_addr] <= in_mass;
        end else if (cmd.op == OP_UWR) begin
            pos_mem[wr_addr]  <= {uy_reg, ux_reg};
            vel_mem[wr_addr]  <= {uvy_reg, uvx_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_CLR) begin
            frc_mem[wr_addr] <= '0;
        end else if ((cmd.op == OP_FWRI) || (cmd.op == OP_FWRJ)) begin
            frc_mem[wr_addr] <= fword;
        end
    end

    // registered reads
    always_ff @(posedge aclk) begin
        pos_rd  <= pos_mem[rd_addr];
        vel_rd  <= vel_mem[rd_addr];
        mass_rd <= mass_mem[rd_addr];
        frc_rd  <= frc_mem[rd_addr];
    end

    // shared multiplier operand select
    always_comb begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            OP_MAA: begin
                ma = {1'b0, a_reg};
                mb = {1'b0, a_reg};
            end
            OP_MBB: begin
                ma = {1'b0, b_reg};
                mb = {1'b0, b_reg};
            end
            OP_MMM: begin
                ma = {1'b0, mi_reg};
                mb = {1'b0, mj_reg};
            end
            OP_PLO: begin
                ma = {1'b0, p_reg[31:0]};
                mb = {1'b0, cmd.comp ? b_reg : a_reg};
            end
            OP_PHI: begin
                ma = {1'b0, p_reg[63:32]};
                mb = {1'b0, cmd.comp ? b_reg : a_reg};
            end
            OP_UMF: begin
                ma = {16'b0, dt};
                mb = cmd.comp ? {ufy_reg[31], ufy_reg} : {ufx_reg[31], ufx_reg};
            end
            OP_UMV: begin
                ma = {16'b0, dt};
                mb = cmd.comp ? {uvy_reg[31], uvy_reg} : {uvx_reg[31], uvx_reg};
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
        mul_next = ma * mb;
    end

    // absolute differences and range shift
    always_comb begin
        ax = dx_reg[32] ? 33'(-dx_reg) : dx_reg;
        ay = dy_reg[32] ? 33'(-dy_reg) : dy_reg;
        kk = ax[32] | ax[31] | ay[32] | ay[31];
    end

    // divider and root start
    always_comb begin
        num1      = {64'b0, mul_reg[63:0]} << FRAC_BITS;
        num2      = {32'b0, mul_reg[63:0], 32'b0} + {64'b0, plo_reg};
        sq_start  = (cmd.op == OP_START1);
        div_start = (cmd.op == OP_START1) || (cmd.op == OP_START2);
        if (cmd.op == OP_START2) begin
            div_hi  = num2[127:64];
            div_lo  = num2[63:0];
            div_den = {32'b0, sq_root};
        end else begin
            div_hi  = num1[127:64];
            div_lo  = num1[63:0];
            div_den = s_reg;
        end
    end

    // force accumulation for i or j
    always_comb begin
        fo_c  = cmd.comp ? frc_rd[63:32] : frc_rd[31:0];
        fmag  = {2'b0, f_reg};
        fneg  = cmd.comp ? dyp_reg : dxp_reg;
        if (cmd.op == OP_FWRJ) begin
            fneg = ~fneg;
        end
        fsum  = 34'(fo_c) + (fneg ? -fmag : fmag);
        fnew  = sat32_fn(64'(fsum));
        fovf  = ovf32_fn(64'(fsum));
        if (cmd.comp) begin
            fword = {frc_rd[64] | fovf | psat_reg, fnew, frc_rd[31:0]};
        end else begin
            fword = {frc_rd[64] | fovf | psat_reg, frc_rd[63:32], fnew};
        end
    end

    // kick and drift sums
    always_comb begin
        dv   = mul_reg >>> FRAC_BITS;
        v_c  = cmd.comp ? uvy_reg : uvx_reg;
        x_c  = cmd.comp ? uy_reg : ux_reg;
        vsum = 64'(v_c) + 64'(dv);
        xsum = 64'(x_c) + 64'(dv);
        idx32 = 32'(wr_addr);
    end

    // pair registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_CAPI: begin
                pix_reg <= pos_rd[31:0];
                piy_reg <= pos_rd[63:32];
                mi_reg  <= mass_rd;
            end
            OP_CAPJ: begin
                dx_reg <= {pix_reg[31], pix_reg} - {pos_rd[31], pos_rd[31:0]};
                dy_reg <= {piy_reg[31], piy_reg} - {pos_rd[63], pos_rd[63:32]};
                mj_reg <= mass_rd;
            end
            OP_ABS: begin
                k_reg   <= kk;
                a_reg   <= kk ? ax[32:1] : ax[31:0];
                b_reg   <= kk ? ay[32:1] : ay[31:0];
                dxp_reg <= !dx_reg[32] && (dx_reg != '0);
                dyp_reg <= !dy_reg[32] && (dy_reg != '0);
            end
            OP_MBB: s_reg <= mul_reg[63:0];
            OP_MMM: s_reg <= s_reg + mul_reg[63:0];
            OP_PCAP: p_reg <= div_q >> {k_reg, 1'b0};
            OP_PHI: plo_reg <= mul_reg[63:0];
            OP_MCAP: begin
                psat_reg <= (div_q > 64'h0000_0000_7FFF_FFFF);
                f_reg    <= (div_q > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : div_q[31:0];
            end
            default: ;
        endcase
    end

    // multiplier output register
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_MAA, OP_MBB, OP_MMM, OP_PLO, OP_PHI, OP_UMF, OP_UMV: mul_reg <= mul_next;
            default: ;
        endcase
    end

    // update registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_UCAP: begin
                ux_reg    <= pos_rd[31:0];
                uy_reg    <= pos_rd[63:32];
                uvx_reg   <= vel_rd[31:0];
                uvy_reg   <= vel_rd[63:32];
                ufx_reg   <= frc_rd[31:0];
                ufy_reg   <= frc_rd[63:32];
                uflag_reg <= frc_rd[64];
            end
            OP_UV: begin
                if (cmd.comp) begin
                    uvy_reg <= sat32_fn(vsum);
                end else begin
                    uvx_reg <= sat32_fn(vsum);
                end
                uflag_reg <= uflag_reg | ovf32_fn(vsum);
            end
            OP_UX: begin
                if (cmd.comp) begin
                    uy_reg <= sat32_fn(xsum);
                end else begin
                    ux_reg <= sat32_fn(xsum);
                end
                uflag_reg <= uflag_reg | ovf32_fn(xsum);
            end
            OP_UWR: begin
                oidx_reg  <= idx32[IDX_OUT_W-1:0];
                opx_reg   <= ux_reg;
                opy_reg   <= uy_reg;
                ovx_reg   <= uvx_reg;
                ovy_reg   <= uvy_reg;
                osat_reg  <= uflag_reg;
                olast_reg <= cmd.last;
            end
            default: ;
        endcase
    end

    assign status.s_zero     = (s_reg == '0);
    assign status.units_idle = !div_busy && !sq_busy;
    assign out_idx   = oidx_reg;
    assign out_pos_x = opx_reg;
    assign out_pos_y = opy_reg;
    assign out_vel_x = ovx_reg;
    assign out_vel_y = ovy_reg;
    assign out_sat   = osat_reg;
    assign out_last  = olast_reg;
endmodule
`default_nettype wire

### rtl/core/gpf_ctrl.sv
// Controller: load counting, pair loop sequencing, update and emit sequencing.
// Depends on gpf_pkg; drives gpf_dp through cmd_t and reads status_t.
`default_nettype none
module gpf_ctrl #(
    parameter int MAX_PARTICLES = gpf_pkg::MAX_PARTICLES_DEF,
    localparam int IDX_W        = $clog2(MAX_PARTICLES),
    localparam int CNT_W        = $clog2(MAX_PARTICLES + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire logic              s_tlast,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire gpf_pkg::status_t  status,
    output gpf_pkg::cmd_t          cmd,
    output logic [IDX_W-1:0]       rd_addr,
    output logic [IDX_W-1:0]       wr_addr
);
    import gpf_pkg::*;

    st_t              state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next, n_reg, n_next;
    logic [CNT_W-1:0] i_reg, i_next, j_reg, j_next, idx_reg, idx_next;
    logic             c_reg, c_next;
    logic [CNT_W-1:0] j1, i1, i2, idx1;
    logic             cnt_room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            idx_reg   <= '0;
            c_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            idx_reg   <= idx_next;
            c_reg     <= c_next;
        end
    end

    always_comb begin
        j1       = j_reg + 1'b1;
        i1       = i_reg + 1'b1;
        i2       = i_reg + CNT_W'(2);
        idx1     = idx_reg + 1'b1;
        cnt_room = (cnt_reg < CNT_W'(MAX_PARTICLES));

        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        idx_next   = idx_reg;
        c_next     = c_reg;
        cmd.op     = OP_NONE;
        cmd.comp   = c_reg;
        cmd.last   = (idx1 == n_reg);
        rd_addr    = i_reg[IDX_W-1:0];
        wr_addr    = idx_reg[IDX_W-1:0];
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                wr_addr  = cnt_reg[IDX_W-1:0];
                if (s_tvalid) begin
                    if (cnt_room) begin
                        cmd.op   = OP_LOAD;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (s_tlast) begin
                        n_next     = cnt_room ? cnt_reg + 1'b1 : cnt_reg;
                        idx_next   = '0;
                        state_next = ST_CLR;
                    end
                end
            end
            // clear force store over the loaded entries
            ST_CLR: begin
                cmd.op = OP_CLR;
                if (idx1 == n_reg) begin
                    idx_next = '0;
                    i_next   = '0;
                    j_next   = CNT_W'(1);
                    state_next = (n_reg > CNT_W'(1)) ? ST_RDI : ST_URD;
                end else begin
                    idx_next = idx1;
                end
            end
            ST_RDI: begin
                rd_addr    = i_reg[IDX_W-1:0];
                state_next = ST_RDJ;
            end
            ST_RDJ: begin
                rd_addr    = j_reg[IDX_W-1:0];
                cmd.op     = OP_CAPI;
                state_next = ST_CAPJ;
            end
            ST_CAPJ: begin
                cmd.op     = OP_CAPJ;
                state_next = ST_ABS;
            end
            ST_ABS: begin
                cmd.op     = OP_ABS;
                state_next = ST_MAA;
            end
            ST_MAA: begin
                cmd.op     = OP_MAA;
                state_next = ST_MBB;
            end
            ST_MBB: begin
                cmd.op     = OP_MBB;
                state_next = ST_MMM;
            end
            ST_MMM: begin
                cmd.op     = OP_MMM;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (!status.s_zero) begin
                    cmd.op     = OP_START1;
                    state_next = ST_W1;
                end
            end
            ST_W1: begin
                if (status.units_idle) begin
                    cmd.op     = OP_PCAP;
                    c_next     = 1'b0;
                    state_next = ST_PLO;
                end
            end
            ST_PLO: begin
                cmd.op     = OP_PLO;
                state_next = ST_PHI;
            end
            ST_PHI: begin
                cmd.op     = OP_PHI;
                state_next = ST_D2S;
            end
            ST_D2S: begin
                cmd.op     = OP_START2;
                state_next = ST_W2;
            end
            ST_W2: begin
                if (status.units_idle) begin
                    cmd.op     = OP_MCAP;
                    state_next = ST_FRDI;
                end
            end
            ST_FRDI: begin
                rd_addr    = i_reg[IDX_W-1:0];
                state_next = ST_FWRI;
            end
            ST_FWRI: begin
                rd_addr    = j_reg[IDX_W-1:0];
                wr_addr    = i_reg[IDX_W-1:0];
                cmd.op     = OP_FWRI;
                state_next = ST_FWRJ;
            end
            ST_FWRJ: begin
                wr_addr = j_reg[IDX_W-1:0];
                cmd.op  = OP_FWRJ;
                if (!c_reg) begin
                    c_next     = 1'b1;
                    state_next = ST_PLO;
                end
            end
            ST_URD: begin
                rd_addr    = idx_reg[IDX_W-1:0];
                state_next = ST_UCAP;
            end
            ST_UCAP: begin
                cmd.op     = OP_UCAP;
                c_next     = 1'b0;
                state_next = ST_UMF;
            end
            ST_UMF: begin
                cmd.op     = OP_UMF;
                state_next = ST_UV;
            end
            ST_UV: begin
                cmd.op     = OP_UV;
                state_next = ST_UMV;
            end
            ST_UMV: begin
                cmd.op     = OP_UMV;
                state_next = ST_UX;
            end
            ST_UX: begin
                cmd.op = OP_UX;
                if (!c_reg) begin
                    c_next     = 1'b1;
                    state_next = ST_UMF;
                end else begin
                    state_next = ST_UWR;
                end
            end
            ST_UWR: begin
                cmd.op     = OP_UWR;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (idx1 == n_reg) begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx1;
                        state_next = ST_URD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // advance to the next pair once a pair is done or skipped
        if (((state_reg == ST_CHK) && status.s_zero) ||
            ((state_reg == ST_FWRJ) && c_reg)) begin
            if (j1 < n_reg) begin
                j_next     = j1;
                state_next = ST_RDI;
            end else if (i2 < n_reg) begin
                i_next     = i1;
                j_next     = i2;
                state_next = ST_RDI;
            end else begin
                idx_next   = '0;
                state_next = ST_URD;
            end
        end
    end
endmodule
`default_nettype wire

### rtl/core/gravity_pair_force_leapfrog_step_core.sv
// Load: one particle per cycle. A step over n particles clears the forces, runs every pair
// (a coincident pair is skipped) and then updates and emits each particle; the pair time is
// set by the shared divider, used three times per non-coincident pair.
// One step at a time; the input is stalled from the last load beat until the final result.
// Reset (aresetn low, synchronous) empties the load count, idles the core, sets dt to 656.
`default_nettype none
module gravity_pair_force_leapfrog_step_core #(
    parameter int MAX_PARTICLES = gpf_pkg::MAX_PARTICLES_DEF,
    parameter int FRAC_BITS     = gpf_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // config: time_step
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [gpf_pkg::DT_W-1:0]        cfg_data,
    // tdata: pos_x, pos_y, vel_x, vel_y, body_mass
    input  wire logic [gpf_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            s_tlast,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // tdata: particle_index, new_pos_x, new_pos_y, new_vel_x, new_vel_y, zero pad
    output logic [gpf_pkg::M_TDATA_W-1:0]        m_tdata,
    // tuser: saturated
    output logic                                 m_tuser,
    output logic                                 m_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready
);
    import gpf_pkg::*;
    localparam int IDX_W = $clog2(MAX_PARTICLES);

    logic [DT_W-1:0]      dt_reg;
    cmd_t                 cmd;
    status_t              status;
    logic [IDX_W-1:0]     rd_addr, wr_addr;
    logic [IDX_OUT_W-1:0] o_idx;
    logic signed [31:0]   o_px, o_py, o_vx, o_vy;

    // time step register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dt_reg <= DT_RESET;
        end else if (cfg_valid) begin
            dt_reg <= cfg_data;
        end
    end

    gpf_ctrl #(.MAX_PARTICLES(MAX_PARTICLES)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tlast(s_tlast), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .status(status), .cmd(cmd), .rd_addr(rd_addr), .wr_addr(wr_addr)
    );

    gpf_dp #(.MAX_PARTICLES(MAX_PARTICLES), .FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .rd_addr(rd_addr), .wr_addr(wr_addr), .dt(dt_reg),
        .in_pos_x(s_tdata[31:0]), .in_pos_y(s_tdata[63:32]),
        .in_vel_x(s_tdata[95:64]), .in_vel_y(s_tdata[127:96]),
        .in_mass(s_tdata[159:128]),
        .status(status),
        .out_idx(o_idx), .out_pos_x(o_px), .out_pos_y(o_py),
        .out_vel_x(o_vx), .out_vel_y(o_vy), .out_sat(m_tuser), .out_last(m_tlast)
    );

    assign m_tdata = {2'b0, o_vy, o_vx, o_py, o_px, o_idx};
endmodule
`default_nettype wire
